// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent on the same edge
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/jrl_pkg.sv -----
// ----------------------------------------------------------------------------
// jrl_pkg
// Types and constants shared by the JPEG run-length symbol generator.
// ----------------------------------------------------------------------------
package jrl_pkg;

   localparam int COEF_W  = 12;
   localparam int COMP_W  = 2;
   localparam int RUN_W   = 4;
   localparam int VALUE_W = 13;
   localparam int CNT_W   = 6;

   localparam logic [CNT_W-1:0] RUN_MAX  = 6'd63;
   localparam logic [CNT_W-1:0] ZRL_RUN  = 6'd15;
   localparam logic [CNT_W-1:0] ZRL_STEP = 6'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DC,
      ST_AC,
      ST_EOB
   } state_type;

   typedef enum logic [1:0] {
      SYM_DC,
      SYM_ZRL,
      SYM_VALUE,
      SYM_EOB
   } sym_type;

   typedef struct packed {
      logic    capture;
      logic    run_inc;
      logic    run_clear;
      logic    run_sub16;
      logic    pos_advance;
      logic    pred_write;
      logic    load;
      logic    last;
      sym_type sym;
   } cmd_type;

   typedef struct packed {
      logic pos_first;
      logic pos_last;
      logic coef_zero;
      logic run_gt15;
      logic out_free;
   } sts_type;

endpackage

// ----- hw/rtl/jrl_ctrl.sv -----
// ----------------------------------------------------------------------------
// jrl_ctrl
// Sequencer: takes one coefficient, then emits its symbols one per cycle while the output register is free.
// ----------------------------------------------------------------------------
module jrl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jrl_pkg::sts_type  sts,
   output jrl_pkg::cmd_type  cmd,
   output jrl_pkg::state_type state
);

   jrl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jrl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.sym   = jrl_pkg::SYM_DC;
      unique case (state_ff)
         jrl_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               priority if (sts.pos_first) begin
                  state_in = jrl_pkg::ST_DC;
               end else if (sts.coef_zero) begin
                  cmd.run_inc = 1'b1;
                  // a zero at the last position always leaves a run pending
                  if (sts.pos_last) begin
                     state_in = jrl_pkg::ST_EOB;
                  end else begin
                     cmd.pos_advance = 1'b1;
                  end
               end else begin
                  state_in = jrl_pkg::ST_AC;
               end
            end
         end
         jrl_pkg::ST_DC: begin
            if (sts.out_free) begin
               cmd.load        = 1'b1;
               cmd.sym         = jrl_pkg::SYM_DC;
               cmd.last        = 1'b1;
               cmd.pred_write  = 1'b1;
               cmd.run_clear   = 1'b1;
               cmd.pos_advance = 1'b1;
               state_in        = jrl_pkg::ST_IDLE;
            end
         end
         jrl_pkg::ST_AC: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               if (sts.run_gt15) begin
                  cmd.sym       = jrl_pkg::SYM_ZRL;
                  cmd.run_sub16 = 1'b1;
               end else begin
                  cmd.sym         = jrl_pkg::SYM_VALUE;
                  cmd.last        = 1'b1;
                  cmd.run_clear   = 1'b1;
                  cmd.pos_advance = 1'b1;
                  state_in        = jrl_pkg::ST_IDLE;
               end
            end
         end
         jrl_pkg::ST_EOB: begin
            if (sts.out_free) begin
               cmd.load        = 1'b1;
               cmd.sym         = jrl_pkg::SYM_EOB;
               cmd.last        = 1'b1;
               cmd.run_clear   = 1'b1;
               cmd.pos_advance = 1'b1;
               state_in        = jrl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jrl_pkg::ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// ----- hw/rtl/jrl_dp.sv -----
// ----------------------------------------------------------------------------
// jrl_dp
// Datapath: item latch, run and position counters, DC predictors and the
// output word register.
// ----------------------------------------------------------------------------
module jrl_dp #(
   parameter int BLOCK_COEFFS   = 64,
   parameter int NUM_COMPONENTS = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [11:0]            req_coefficient,
   input  logic        [1:0]             req_component,
   input  jrl_pkg::cmd_type              cmd,
   output jrl_pkg::sts_type              sts,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_dc,
   output logic                          rsp_is_chroma,
   output logic        [3:0]             rsp_zero_run,
   output logic signed [12:0]            rsp_symbol_value,
   output logic                          rsp_last_of_item
);

   localparam int PosW = $clog2(BLOCK_COEFFS);
   localparam logic [PosW-1:0] PosLast = PosW'(BLOCK_COEFFS - 1);

   logic signed [11:0] item_coef_ff;
   logic        [1:0]  item_comp_ff;
   logic        [5:0]  run_ff, run_in;
   logic [PosW-1:0]    pos_ff, pos_in;
   logic signed [11:0] pred_ff [NUM_COMPONENTS];
   logic signed [11:0] pred_sel;
   logic signed [12:0] dc_diff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               is_dc_ff, is_chroma_ff, last_ff;
   logic        [3:0]  zero_run_ff;
   logic signed [12:0] value_ff;
   logic        [3:0]  zero_run_in;
   logic signed [12:0] value_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_coef_ff <= req_coefficient;
         item_comp_ff <= req_component;
      end
   end

   // run count: saturating increment, ZRL steps down by 16
   always_comb begin
      run_in = run_ff;
      priority if (cmd.run_clear) begin
         run_in = '0;
      end else if (cmd.run_sub16) begin
         run_in = run_ff - jrl_pkg::ZRL_STEP;
      end else if (cmd.run_inc && run_ff != jrl_pkg::RUN_MAX) begin
         run_in = run_ff + 6'd1;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.pos_advance) begin
         pos_in = (pos_ff == PosLast) ? '0 : pos_ff + PosW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         pos_ff <= '0;
      end else begin
         run_ff <= run_in;
         pos_ff <= pos_in;
      end
   end

   // components without a predictor slot compare against zero
   always_comb begin
      pred_sel = '0;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
         if (item_comp_ff == 2'(i)) begin
            pred_sel = pred_ff[i];
         end
      end
   end

   assign dc_diff = 13'(item_coef_ff) - 13'(pred_sel);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COMPONENTS; i++) begin
            pred_ff[i] <= '0;
         end
      end else if (cmd.pred_write) begin
         for (int i = 0; i < NUM_COMPONENTS; i++) begin
            if (item_comp_ff == 2'(i)) begin
               pred_ff[i] <= item_coef_ff;
            end
         end
      end
   end

   always_comb begin
      unique case (cmd.sym)
         jrl_pkg::SYM_DC: begin
            zero_run_in = '0;
            value_in    = dc_diff;
         end
         jrl_pkg::SYM_ZRL: begin
            zero_run_in = jrl_pkg::ZRL_RUN[3:0];
            value_in    = '0;
         end
         jrl_pkg::SYM_VALUE: begin
            zero_run_in = run_ff[3:0];
            value_in    = 13'(item_coef_ff);
         end
         jrl_pkg::SYM_EOB: begin
            zero_run_in = '0;
            value_in    = '0;
         end
         default: begin
            zero_run_in = '0;
            value_in    = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_dc_ff     <= (cmd.sym == jrl_pkg::SYM_DC);
         is_chroma_ff <= (item_comp_ff != '0);
         zero_run_ff  <= zero_run_in;
         value_ff     <= value_in;
         last_ff      <= cmd.last;
      end
   end

   assign sts.pos_first = (pos_ff == '0);
   assign sts.pos_last  = (pos_ff == PosLast);
   assign sts.coef_zero = (req_coefficient == '0);
   assign sts.run_gt15  = (run_ff > jrl_pkg::ZRL_RUN);
   assign sts.out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_dc        = is_dc_ff;
   assign rsp_is_chroma    = is_chroma_ff;
   assign rsp_zero_run     = zero_run_ff;
   assign rsp_symbol_value = value_ff;
   assign rsp_last_of_item = last_ff;

endmodule

// ----- hw/rtl/jpeg_coefficient_run_length_symbols.sv -----
// Timing: the accept moves the sequencer to its DC, AC or EOB state; it then fills the
//   single output register one word a cycle while that register is free. A zero AC
//   coefficient that emits nothing leaves the sequencer idle, ready to accept; any other
//   item holds req_stall high until its last word (1 to 4 words per item) is loaded.
// Reset: synchronous; clears predictors, run count, position and output valid.
// ----------------------------------------------------------------------------
// jpeg_coefficient_run_length_symbols
// JPEG baseline DC difference and AC run-length symbol generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jpeg_coefficient_run_length_symbols #(
   parameter int BLOCK_COEFFS   = 64,
   parameter int NUM_COMPONENTS = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [11:0] req_coefficient,
   input  logic        [1:0]  req_component,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_is_dc,
   output logic               rsp_is_chroma,
   output logic        [3:0]  rsp_zero_run,
   output logic signed [12:0] rsp_symbol_value,
   output logic               rsp_last_of_item
);

   jrl_pkg::cmd_type   cmd;
   jrl_pkg::sts_type   sts;
   jrl_pkg::state_type state;

   jrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd),
      .state     (state)
   );

   jrl_dp #(
      .BLOCK_COEFFS   (BLOCK_COEFFS),
      .NUM_COMPONENTS (NUM_COMPONENTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_coefficient  (req_coefficient),
      .req_component    (req_component),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_dc        (rsp_is_dc),
      .rsp_is_chroma    (rsp_is_chroma),
      .rsp_zero_run     (rsp_zero_run),
      .rsp_symbol_value (rsp_symbol_value),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // ZRL word is never the last word of an item
   `ASSERT_IMPLY(a_zrl_not_last, clock, reset,
      rsp_valid && !rsp_is_dc && rsp_zero_run == 4'd15 && rsp_symbol_value == '0,
      !rsp_last_of_item)

   // EOB closes its item; DC word carries no run and closes its item
   `ASSERT_IMPLY(a_eob_last, clock, reset,
      rsp_valid && !rsp_is_dc && rsp_zero_run == '0 && rsp_symbol_value == '0,
      rsp_last_of_item)
   `ASSERT_IMPLY(a_dc_word, clock, reset,
      rsp_valid && rsp_is_dc, rsp_last_of_item && rsp_zero_run == '0)

   // loading the DC word returns the sequencer to idle, able to accept
   `ASSERT_NEXT(a_dc_returns_idle, clock, reset,
      state == jrl_pkg::ST_DC && sts.out_free, state == jrl_pkg::ST_IDLE)

endmodule
